// ----- rtl/glf_pkg.sv -----
// ----------------------------------------------------------------------------
// glf_pkg: shared types and constants of the Gaussian leapfrog step block
// Word format, configuration register map, reset values and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package glf_pkg;

	// Fixed-point word format
	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * WORD_W;

	// Configuration field widths
	localparam int SD_W      = 24;
	localparam int N_W       = 16;
	localparam int EPS_W     = 20;
	localparam int CFG_IDX_W = 3;

	// Gain computation widths: sigma^2, denominator, divider operands
	localparam int SQ_W   = 2 * SD_W - FRAC_W + 1;
	localparam int DEN_W  = SQ_W + 1;
	localparam int DIVN_W = DEN_W + FRAC_W;
	localparam int DIVR_W = DEN_W + 1;
	localparam int DCNT_W = $clog2(DIVN_W);

	localparam logic [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam logic [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_POS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_MOM    = 3'd4;

	// Reset configuration and the gains that follow from it
	localparam logic [SD_W-1:0]   NOISE_SD_RST = 24'd131072;
	localparam logic [N_W-1:0]    COUNT_RST    = 16'd500;
	localparam logic [EPS_W-1:0]  EPS_RST      = 20'd3277;
	localparam logic [WORD_W-1:0] MSG_RST      = 32'd65015;
	localparam logic [WORD_W-1:0] GG_RST       = 32'd8257536;

	// Multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_MEAN_MSG,
		MUL_GG_OPD,
		MUL_EPS_OPD,
		MUL_EPS_MOM,
		MUL_SD_SD
	} mul_sel_t;

	// Destination of the rounded product
	typedef enum logic [2:0] {
		RND_NONE,
		RND_TGT,
		RND_OPD,
		RND_TERM,
		RND_SQ
	} rnd_dst_t;

	// Saturating add/subtract operations
	typedef enum logic [1:0] {
		ALU_NONE,
		ALU_DIFF,
		ALU_MOM_SUB,
		ALU_POS_ADD
	} alu_op_t;

	// Gain register updates
	typedef enum logic [1:0] {
		GAIN_NONE,
		GAIN_DEN,
		GAIN_MSG,
		GAIN_GG
	} gain_op_t;

	typedef enum logic {
		DIV_MSG,
		DIV_GG
	} div_sel_t;

	typedef struct packed {
		logic     cfg_we;
		logic     take_step;
		logic     restart;
		logic     mul_en;
		mul_sel_t mul_sel;
		rnd_dst_t rnd_dst;
		logic     rnd_half;
		alu_op_t  alu_op;
		gain_op_t gain_op;
		logic     div_start;
		div_sel_t div_sel;
		logic     out_load;
	} glf_cmd_t;

	typedef struct packed {
		logic gain_req;
		logic restart_req;
		logic div_done;
	} glf_sts_t;

endpackage

// ----- rtl/glf_in_if.sv -----
// ----------------------------------------------------------------------------
// glf_in_if: input item channel
// Carries the command bit and the batch mean with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface glf_in_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic signed [glf_pkg::WORD_W-1:0]   batch_mean;

	modport source (output valid, output command, output batch_mean, input ready);
	modport sink (input valid, input command, input batch_mean, output ready);
endinterface

// ----- rtl/glf_out_if.sv -----
// ----------------------------------------------------------------------------
// glf_out_if: result channel
// Carries position, momentum and the saturation flag with valid/ready.
// ----------------------------------------------------------------------------
interface glf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [glf_pkg::WORD_W-1:0]   position;
	logic signed [glf_pkg::WORD_W-1:0]   momentum;
	logic                                saturated;

	modport source (output valid, output position, output momentum, output saturated,
		input ready);
	modport sink (input valid, input position, input momentum, input saturated,
		output ready);
endinterface

// ----- rtl/glf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// glf_cfg_if: configuration write channel
// Carries a register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface glf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [glf_pkg::CFG_IDX_W-1:0]     index;
	logic [glf_pkg::WORD_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/glf_div.sv -----
// ----------------------------------------------------------------------------
// glf_div: iterative restoring divider for the gain computation
// One quotient bit per cycle; the quotient is clamped to the largest word.
// ----------------------------------------------------------------------------
module glf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [glf_pkg::DIVN_W-1:0]    dividend,
	input  logic [glf_pkg::DEN_W-1:0]     divisor,
	output logic                          done,
	output logic [glf_pkg::WORD_W-1:0]    quotient
);
	import glf_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVN_W-1:0] num_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DEN_W-1:0]  dsr_q;
	logic [WORD_W-1:0] quo_q;
	logic              ovf_q;

	logic [DIVR_W-1:0] rem_sh;
	logic              rem_ge;
	logic [DIVR_W-1:0] rem_nx;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_sh = {rem_q[DIVR_W-2:0], num_q[DIVN_W-1]};
		rem_ge = rem_sh >= {1'b0, dsr_q};
		rem_nx = rem_ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
	end

	// Sequence the bit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIVN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[DIVN_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[WORD_W-2:0], rem_ge};
			ovf_q <= ovf_q | quo_q[WORD_W-1];
		end
	end

	assign done     = done_q;
	assign quotient = (ovf_q || quo_q[WORD_W-1]) ? WMAX : quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// ----- rtl/glf_dp.sv -----
// ----------------------------------------------------------------------------
// glf_dp: datapath of the Gaussian leapfrog step
// Configuration registers, gains, position/momentum state, one shared
// multiplier with a rounding/clamp stage, a saturating adder and the divider.
// ----------------------------------------------------------------------------
module glf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  glf_pkg::glf_cmd_t             cmd,
	output glf_pkg::glf_sts_t             sts,
	input  logic                          command,
	input  logic [glf_pkg::WORD_W-1:0]    batch_mean,
	input  logic [glf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [glf_pkg::WORD_W-1:0]    cfg_data,
	output logic [glf_pkg::WORD_W-1:0]    position,
	output logic [glf_pkg::WORD_W-1:0]    momentum,
	output logic                          saturated
);
	import glf_pkg::*;

	// Configuration
	logic [SD_W-1:0]   noise_sd_q;
	logic [N_W-1:0]    count_q;
	logic [EPS_W-1:0]  eps_q;
	logic [WORD_W-1:0] start_pos_q;
	logic [WORD_W-1:0] start_mom_q;

	// Gains and their intermediates
	logic [WORD_W-1:0] msg_q;
	logic [WORD_W-1:0] gg_q;
	logic [SQ_W-1:0]   sq_q;
	logic [DEN_W-1:0]  den_q;
	logic [WORD_W-1:0] nf;

	// Step state and work registers
	logic [WORD_W-1:0] pos_q;
	logic [WORD_W-1:0] mom_q;
	logic [WORD_W-1:0] mean_q;
	logic [WORD_W-1:0] tgt_q;
	logic [WORD_W-1:0] opd_q;
	logic [WORD_W-1:0] term_q;
	logic              flag_q;

	// Result register
	logic [WORD_W-1:0] res_pos_q;
	logic [WORD_W-1:0] res_mom_q;
	logic              res_sat_q;

	// Multiplier
	logic [WORD_W-1:0] op_a;
	logic [WORD_W-1:0] op_b;
	logic [WORD_W-1:0] mag_a;
	logic [WORD_W-1:0] mag_b;
	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;

	// Rounding and clamp
	logic [PROD_W-1:0] rnd_add;
	logic [PROD_W-1:0] rnd_sum;
	logic [PROD_W-1:0] rnd_mag;
	logic [WORD_W-1:0] rnd_val;
	logic              rnd_ovf;

	// Saturating adder
	logic [WORD_W-1:0] alu_a;
	logic [WORD_W-1:0] alu_b;
	logic              alu_sub;
	logic [WORD_W:0]   alu_sum;
	logic [WORD_W-1:0] alu_val;
	logic              alu_ovf;

	// Divider
	logic [DIVN_W-1:0] div_num;
	logic [DEN_W-1:0]  div_dsr;
	logic              div_done;
	logic [WORD_W-1:0] div_quo;

	assign nf = {count_q, {FRAC_W{1'b0}}};

	// Decode status for the controller
	assign sts.gain_req    = (cfg_index == REG_NOISE_SD) || (cfg_index == REG_SAMPLE_COUNT);
	assign sts.restart_req = command;
	assign sts.div_done    = div_done;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_sd_q  <= NOISE_SD_RST;
			count_q     <= COUNT_RST;
			eps_q       <= EPS_RST;
			start_pos_q <= '0;
			start_mom_q <= '0;
		end else if (cmd.cfg_we) begin
			unique case (cfg_index)
				REG_NOISE_SD:     noise_sd_q  <= cfg_data[SD_W-1:0];
				REG_SAMPLE_COUNT: count_q     <= cfg_data[N_W-1:0];
				REG_STEP_SIZE:    eps_q       <= cfg_data[EPS_W-1:0];
				REG_START_POS:    start_pos_q <= cfg_data;
				REG_START_MOM:    start_mom_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Select multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			MUL_MEAN_MSG: begin
				op_a = mean_q;
				op_b = msg_q;
			end
			MUL_GG_OPD: begin
				op_a = gg_q;
				op_b = opd_q;
			end
			MUL_EPS_OPD: begin
				op_a = WORD_W'(eps_q);
				op_b = opd_q;
			end
			MUL_EPS_MOM: begin
				op_a = WORD_W'(eps_q);
				op_b = mom_q;
			end
			MUL_SD_SD: begin
				op_a = WORD_W'(noise_sd_q);
				op_b = WORD_W'(noise_sd_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		mag_a = op_a[WORD_W-1] ? (~op_a + 1'b1) : op_a;
		mag_b = op_b[WORD_W-1] ? (~op_b + 1'b1) : op_b;
	end

	// Multiply magnitudes, keep the sign apart
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= PROD_W'(mag_a) * PROD_W'(mag_b);
			neg_s1  <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
		end
	end

	// Round magnitude (halved on request) half away from zero, restore sign, clamp
	always_comb begin
		rnd_add = cmd.rnd_half ? (PROD_W'(1) << FRAC_W) : (PROD_W'(1) << (FRAC_W - 1));
		rnd_sum = prod_s1 + rnd_add;
		rnd_mag = cmd.rnd_half ? (rnd_sum >> (FRAC_W + 1)) : (rnd_sum >> FRAC_W);
		rnd_ovf = 1'b0;
		if (neg_s1) begin
			if (rnd_mag > PROD_W'(WMIN)) begin
				rnd_val = WMIN;
				rnd_ovf = 1'b1;
			end else begin
				rnd_val = ~rnd_mag[WORD_W-1:0] + 1'b1;
			end
		end else begin
			if (rnd_mag > PROD_W'(WMAX)) begin
				rnd_val = WMAX;
				rnd_ovf = 1'b1;
			end else begin
				rnd_val = rnd_mag[WORD_W-1:0];
			end
		end
	end

	// Saturating add/subtract
	always_comb begin
		case (cmd.alu_op)
			ALU_MOM_SUB: begin
				alu_a   = mom_q;
				alu_b   = term_q;
				alu_sub = 1'b1;
			end
			ALU_POS_ADD: begin
				alu_a   = pos_q;
				alu_b   = term_q;
				alu_sub = 1'b0;
			end
			default: begin
				alu_a   = pos_q;
				alu_b   = tgt_q;
				alu_sub = 1'b1;
			end
		endcase
		alu_sum = alu_sub ? ({alu_a[WORD_W-1], alu_a} - {alu_b[WORD_W-1], alu_b})
			: ({alu_a[WORD_W-1], alu_a} + {alu_b[WORD_W-1], alu_b});
		alu_ovf = alu_sum[WORD_W] != alu_sum[WORD_W-1];
		if (alu_ovf) begin
			alu_val = alu_sum[WORD_W] ? WMIN : WMAX;
		end else begin
			alu_val = alu_sum[WORD_W-1:0];
		end
	end

	// Advance position and momentum state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mom_q  <= '0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				pos_q <= start_pos_q;
				mom_q <= start_mom_q;
			end else if (cmd.alu_op == ALU_MOM_SUB) begin
				mom_q <= alu_val;
			end else if (cmd.alu_op == ALU_POS_ADD) begin
				pos_q <= alu_val;
			end
			if (cmd.restart || cmd.take_step) begin
				flag_q <= 1'b0;
			end else begin
				flag_q <= flag_q
					| (rnd_ovf && (cmd.rnd_dst != RND_NONE) && (cmd.rnd_dst != RND_SQ))
					| (alu_ovf && (cmd.alu_op != ALU_NONE));
			end
		end
	end

	// Work registers of one step
	always_ff @(posedge clk) begin
		if (cmd.take_step) begin
			mean_q <= batch_mean;
		end
		case (cmd.rnd_dst)
			RND_TGT:  tgt_q  <= rnd_val;
			RND_OPD:  opd_q  <= rnd_val;
			RND_TERM: term_q <= rnd_val;
			RND_SQ:   sq_q   <= rnd_mag[SQ_W-1:0];
			default:  ;
		endcase
		if (cmd.alu_op == ALU_DIFF) begin
			opd_q <= alu_val;
		end
		if (cmd.gain_op == GAIN_DEN) begin
			den_q <= DEN_W'(sq_q) + DEN_W'(nf);
		end
		if (cmd.out_load) begin
			res_pos_q <= pos_q;
			res_mom_q <= mom_q;
			res_sat_q <= flag_q;
		end
	end

	// Gain registers, reset to the gains of the reset configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_q <= MSG_RST;
			gg_q  <= GG_RST;
		end else begin
			case (cmd.gain_op)
				GAIN_MSG: msg_q <= (den_q == '0) ? '0 : div_quo;
				GAIN_GG:  gg_q  <= (sq_q == '0) ? WMAX : div_quo;
				default:  ;
			endcase
		end
	end

	// Divider operands: N*2^F/den or den/sigma^2, both scaled by 2^F
	always_comb begin
		case (cmd.div_sel)
			DIV_GG: begin
				div_num = {den_q, {FRAC_W{1'b0}}};
				div_dsr = DEN_W'(sq_q);
			end
			default: begin
				div_num = DIVN_W'({nf, {FRAC_W{1'b0}}});
				div_dsr = den_q;
			end
		endcase
	end

	glf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign position  = res_pos_q;
	assign momentum  = res_mom_q;
	assign saturated = res_sat_q;

endmodule

// ----- rtl/glf_ctrl.sv -----
// ----------------------------------------------------------------------------
// glf_ctrl: controller of the Gaussian leapfrog step
// Sequences the kick/drift/kick micro-operations, the gain recompute after a
// configuration write and the result word handoff.
// ----------------------------------------------------------------------------
module glf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  glf_pkg::glf_sts_t sts,
	output glf_pkg::glf_cmd_t cmd
);
	import glf_pkg::*;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_M1      = 5'd1;
	localparam logic [4:0] S_R1      = 5'd2;
	localparam logic [4:0] S_D1      = 5'd3;
	localparam logic [4:0] S_M2      = 5'd4;
	localparam logic [4:0] S_R2      = 5'd5;
	localparam logic [4:0] S_M3      = 5'd6;
	localparam logic [4:0] S_R3      = 5'd7;
	localparam logic [4:0] S_A3      = 5'd8;
	localparam logic [4:0] S_M4      = 5'd9;
	localparam logic [4:0] S_R4      = 5'd10;
	localparam logic [4:0] S_A4      = 5'd11;
	localparam logic [4:0] S_D2      = 5'd12;
	localparam logic [4:0] S_M5      = 5'd13;
	localparam logic [4:0] S_R5      = 5'd14;
	localparam logic [4:0] S_M6      = 5'd15;
	localparam logic [4:0] S_R6      = 5'd16;
	localparam logic [4:0] S_A6      = 5'd17;
	localparam logic [4:0] S_OUT     = 5'd18;
	localparam logic [4:0] S_G_SQ    = 5'd19;
	localparam logic [4:0] S_G_RSQ   = 5'd20;
	localparam logic [4:0] S_G_DEN   = 5'd21;
	localparam logic [4:0] S_G_DIV1  = 5'd22;
	localparam logic [4:0] S_G_WAIT1 = 5'd23;
	localparam logic [4:0] S_G_DIV2  = 5'd24;
	localparam logic [4:0] S_G_WAIT2 = 5'd25;

	logic [4:0] state_q;
	logic [4:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = state_q == S_IDLE;
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign out_valid = out_valid_q;

	// Decode state into datapath commands
	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.cfg_we = cfg_valid;
				if (cfg_valid) begin
					if (sts.gain_req) begin
						state_nx = S_G_SQ;
					end
				end else if (in_valid) begin
					if (sts.restart_req) begin
						cmd.restart = 1'b1;
						state_nx    = S_OUT;
					end else begin
						cmd.take_step = 1'b1;
						state_nx      = S_M1;
					end
				end
			end
			// target = mean * shrink gain
			S_M1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MEAN_MSG;
				state_nx    = S_R1;
			end
			S_R1: begin
				cmd.rnd_dst = RND_TGT;
				state_nx    = S_D1;
			end
			// first half kick
			S_D1: begin
				cmd.alu_op = ALU_DIFF;
				state_nx   = S_M2;
			end
			S_M2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GG_OPD;
				state_nx    = S_R2;
			end
			S_R2: begin
				cmd.rnd_dst = RND_OPD;
				state_nx    = S_M3;
			end
			S_M3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_EPS_OPD;
				state_nx    = S_R3;
			end
			S_R3: begin
				cmd.rnd_dst  = RND_TERM;
				cmd.rnd_half = 1'b1;
				state_nx     = S_A3;
			end
			S_A3: begin
				cmd.alu_op = ALU_MOM_SUB;
				state_nx   = S_M4;
			end
			// full drift
			S_M4: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_EPS_MOM;
				state_nx    = S_R4;
			end
			S_R4: begin
				cmd.rnd_dst = RND_TERM;
				state_nx    = S_A4;
			end
			S_A4: begin
				cmd.alu_op = ALU_POS_ADD;
				state_nx   = S_D2;
			end
			// second half kick
			S_D2: begin
				cmd.alu_op = ALU_DIFF;
				state_nx   = S_M5;
			end
			S_M5: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_GG_OPD;
				state_nx    = S_R5;
			end
			S_R5: begin
				cmd.rnd_dst = RND_OPD;
				state_nx    = S_M6;
			end
			S_M6: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_EPS_OPD;
				state_nx    = S_R6;
			end
			S_R6: begin
				cmd.rnd_dst  = RND_TERM;
				cmd.rnd_half = 1'b1;
				state_nx     = S_A6;
			end
			S_A6: begin
				cmd.alu_op = ALU_MOM_SUB;
				state_nx   = S_OUT;
			end
			// hand the result word to the output register
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			// gain recompute: sigma^2, den, then the two divisions
			S_G_SQ: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SD_SD;
				state_nx    = S_G_RSQ;
			end
			S_G_RSQ: begin
				cmd.rnd_dst = RND_SQ;
				state_nx    = S_G_DEN;
			end
			S_G_DEN: begin
				cmd.gain_op = GAIN_DEN;
				state_nx    = S_G_DIV1;
			end
			S_G_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MSG;
				state_nx      = S_G_WAIT1;
			end
			S_G_WAIT1: begin
				cmd.div_sel = DIV_MSG;
				if (sts.div_done) begin
					cmd.gain_op = GAIN_MSG;
					state_nx    = S_G_DIV2;
				end
			end
			S_G_DIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_GG;
				state_nx      = S_G_WAIT2;
			end
			S_G_WAIT2: begin
				cmd.div_sel = DIV_GG;
				if (sts.div_done) begin
					cmd.gain_op = GAIN_GG;
					state_nx    = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Advance state, hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !sts.restart_req) |=> (state_q == S_M1))
		else $error("accepted step word did not start the step sequence");

	a_gain_start: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && sts.gain_req) |=> (state_q == S_G_SQ))
		else $error("gain register write did not start the gain recompute");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result word not presented after the step");

endmodule

// ----- rtl/gaussian_leapfrog_step_top.sv -----
// ----------------------------------------------------------------------------
// gaussian_leapfrog_step_top: leapfrog integrator for a Gaussian mean posterior
// Top level joining the controller and the datapath to the three channels.
// ----------------------------------------------------------------------------
// Each input word is either a restart (position and momentum reload the start
// registers) or one leapfrog step: half momentum kick, full position drift,
// half kick, with gradient gain*(position - target) and target = batch_mean *
// shrink gain, all in saturating signed Q16.16. One result word comes out per
// input word. A step passes through its micro-operations to the result
// register and a restart goes there directly; a new word is taken only
// once the controller is back in idle. All products go through a single
// shared 32x32 multiplier followed by a rounding stage and a saturating
// adder, so the step is a chain of 17 dependent micro-operations. The next
// word is taken as soon as the result is in the output register, even while
// it waits.
// Writing noise_sd or sample_count starts a gain recompute that keeps the
// block busy through sigma^2, the denominator and two bit-serial divisions
// with their start and load steps, during which no input word and no
// further configuration write is accepted.
module gaussian_leapfrog_step_top (
	input  logic       clk,
	input  logic       arst_n,
	glf_in_if.sink     in_ch,
	glf_out_if.source  out_ch,
	glf_cfg_if.sink    cfg_ch
);
	import glf_pkg::*;

	glf_cmd_t          cmd;
	glf_sts_t          sts;
	logic [WORD_W-1:0] res_pos;
	logic [WORD_W-1:0] res_mom;
	logic              res_sat;

	glf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.cfg_valid (cfg_ch.valid),
		.cfg_ready (cfg_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	glf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.command    (in_ch.command),
		.batch_mean (in_ch.batch_mean),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.position   (res_pos),
		.momentum   (res_mom),
		.saturated  (res_sat)
	);

	assign out_ch.position  = res_pos;
	assign out_ch.momentum  = res_mom;
	assign out_ch.saturated = res_sat;

endmodule
